FILE: sv/aes128_block_encrypt_macros.svh
// Assertion macros shared by the AES-128 checker.
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: sv/aes_pkg.sv
// Types, constants and GF(2^8) helper functions for the AES-128 encryptor.
package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned RegKeyHigh = 0;
    localparam int unsigned RegKeyLow = 1;
    localparam logic [0:0] CfgKeyHigh = 1'b0;
    localparam logic [0:0] CfgKeyLow = 1'b1;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } plain_beat_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } cipher_beat_t;

    // multiply by x in GF(2^8) with the AES polynomial
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // forward S-box as a constant table
    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] s;
        begin
            case (x)
                8'h00: s=8'h63; 8'h01: s=8'h7c; 8'h02: s=8'h77; 8'h03: s=8'h7b;
                8'h04: s=8'hf2; 8'h05: s=8'h6b; 8'h06: s=8'h6f; 8'h07: s=8'hc5;
                8'h08: s=8'h30; 8'h09: s=8'h01; 8'h0a: s=8'h67; 8'h0b: s=8'h2b;
                8'h0c: s=8'hfe; 8'h0d: s=8'hd7; 8'h0e: s=8'hab; 8'h0f: s=8'h76;
                8'h10: s=8'hca; 8'h11: s=8'h82; 8'h12: s=8'hc9; 8'h13: s=8'h7d;
                8'h14: s=8'hfa; 8'h15: s=8'h59; 8'h16: s=8'h47; 8'h17: s=8'hf0;
                8'h18: s=8'had; 8'h19: s=8'hd4; 8'h1a: s=8'ha2; 8'h1b: s=8'haf;
                8'h1c: s=8'h9c; 8'h1d: s=8'ha4; 8'h1e: s=8'h72; 8'h1f: s=8'hc0;
                8'h20: s=8'hb7; 8'h21: s=8'hfd; 8'h22: s=8'h93; 8'h23: s=8'h26;
                8'h24: s=8'h36; 8'h25: s=8'h3f; 8'h26: s=8'hf7; 8'h27: s=8'hcc;
                8'h28: s=8'h34; 8'h29: s=8'ha5; 8'h2a: s=8'he5; 8'h2b: s=8'hf1;
                8'h2c: s=8'h71; 8'h2d: s=8'hd8; 8'h2e: s=8'h31; 8'h2f: s=8'h15;
                8'h30: s=8'h04; 8'h31: s=8'hc7; 8'h32: s=8'h23; 8'h33: s=8'hc3;
                8'h34: s=8'h18; 8'h35: s=8'h96; 8'h36: s=8'h05; 8'h37: s=8'h9a;
                8'h38: s=8'h07; 8'h39: s=8'h12; 8'h3a: s=8'h80; 8'h3b: s=8'he2;
                8'h3c: s=8'heb; 8'h3d: s=8'h27; 8'h3e: s=8'hb2; 8'h3f: s=8'h75;
                8'h40: s=8'h09; 8'h41: s=8'h83; 8'h42: s=8'h2c; 8'h43: s=8'h1a;
                8'h44: s=8'h1b; 8'h45: s=8'h6e; 8'h46: s=8'h5a; 8'h47: s=8'ha0;
                8'h48: s=8'h52; 8'h49: s=8'h3b; 8'h4a: s=8'hd6; 8'h4b: s=8'hb3;
                8'h4c: s=8'h29; 8'h4d: s=8'he3; 8'h4e: s=8'h2f; 8'h4f: s=8'h84;
                8'h50: s=8'h53; 8'h51: s=8'hd1; 8'h52: s=8'h00; 8'h53: s=8'hed;
                8'h54: s=8'h20; 8'h55: s=8'hfc; 8'h56: s=8'hb1; 8'h57: s=8'h5b;
                8'h58: s=8'h6a; 8'h59: s=8'hcb; 8'h5a: s=8'hbe; 8'h5b: s=8'h39;
                8'h5c: s=8'h4a; 8'h5d: s=8'h4c; 8'h5e: s=8'h58; 8'h5f: s=8'hcf;
                8'h60: s=8'hd0; 8'h61: s=8'hef; 8'h62: s=8'haa; 8'h63: s=8'hfb;
                8'h64: s=8'h43; 8'h65: s=8'h4d; 8'h66: s=8'h33; 8'h67: s=8'h85;
                8'h68: s=8'h45; 8'h69: s=8'hf9; 8'h6a: s=8'h02; 8'h6b: s=8'h7f;
                8'h6c: s=8'h50; 8'h6d: s=8'h3c; 8'h6e: s=8'h9f; 8'h6f: s=8'ha8;
                8'h70: s=8'h51; 8'h71: s=8'ha3; 8'h72: s=8'h40; 8'h73: s=8'h8f;
                8'h74: s=8'h92; 8'h75: s=8'h9d; 8'h76: s=8'h38; 8'h77: s=8'hf5;
                8'h78: s=8'hbc; 8'h79: s=8'hb6; 8'h7a: s=8'hda; 8'h7b: s=8'h21;
                8'h7c: s=8'h10; 8'h7d: s=8'hff; 8'h7e: s=8'hf3; 8'h7f: s=8'hd2;
                8'h80: s=8'hcd; 8'h81: s=8'h0c; 8'h82: s=8'h13; 8'h83: s=8'hec;
                8'h84: s=8'h5f; 8'h85: s=8'h97; 8'h86: s=8'h44; 8'h87: s=8'h17;
                8'h88: s=8'hc4; 8'h89: s=8'ha7; 8'h8a: s=8'h7e; 8'h8b: s=8'h3d;
                8'h8c: s=8'h64; 8'h8d: s=8'h5d; 8'h8e: s=8'h19; 8'h8f: s=8'h73;
                8'h90: s=8'h60; 8'h91: s=8'h81; 8'h92: s=8'h4f; 8'h93: s=8'hdc;
                8'h94: s=8'h22; 8'h95: s=8'h2a; 8'h96: s=8'h90; 8'h97: s=8'h88;
                8'h98: s=8'h46; 8'h99: s=8'hee; 8'h9a: s=8'hb8; 8'h9b: s=8'h14;
                8'h9c: s=8'hde; 8'h9d: s=8'h5e; 8'h9e: s=8'h0b; 8'h9f: s=8'hdb;
                8'ha0: s=8'he0; 8'ha1: s=8'h32; 8'ha2: s=8'h3a; 8'ha3: s=8'h0a;
                8'ha4: s=8'h49; 8'ha5: s=8'h06; 8'ha6: s=8'h24; 8'ha7: s=8'h5c;
                8'ha8: s=8'hc2; 8'ha9: s=8'hd3; 8'haa: s=8'hac; 8'hab: s=8'h62;
                8'hac: s=8'h91; 8'had: s=8'h95; 8'hae: s=8'he4; 8'haf: s=8'h79;
                8'hb0: s=8'he7; 8'hb1: s=8'hc8; 8'hb2: s=8'h37; 8'hb3: s=8'h6d;
                8'hb4: s=8'h8d; 8'hb5: s=8'hd5; 8'hb6: s=8'h4e; 8'hb7: s=8'ha9;
                8'hb8: s=8'h6c; 8'hb9: s=8'h56; 8'hba: s=8'hf4; 8'hbb: s=8'hea;
                8'hbc: s=8'h65; 8'hbd: s=8'h7a; 8'hbe: s=8'hae; 8'hbf: s=8'h08;
                8'hc0: s=8'hba; 8'hc1: s=8'h78; 8'hc2: s=8'h25; 8'hc3: s=8'h2e;
                8'hc4: s=8'h1c; 8'hc5: s=8'ha6; 8'hc6: s=8'hb4; 8'hc7: s=8'hc6;
                8'hc8: s=8'he8; 8'hc9: s=8'hdd; 8'hca: s=8'h74; 8'hcb: s=8'h1f;
                8'hcc: s=8'h4b; 8'hcd: s=8'hbd; 8'hce: s=8'h8b; 8'hcf: s=8'h8a;
                8'hd0: s=8'h70; 8'hd1: s=8'h3e; 8'hd2: s=8'hb5; 8'hd3: s=8'h66;
                8'hd4: s=8'h48; 8'hd5: s=8'h03; 8'hd6: s=8'hf6; 8'hd7: s=8'h0e;
                8'hd8: s=8'h61; 8'hd9: s=8'h35; 8'hda: s=8'h57; 8'hdb: s=8'hb9;
                8'hdc: s=8'h86; 8'hdd: s=8'hc1; 8'hde: s=8'h1d; 8'hdf: s=8'h9e;
                8'he0: s=8'he1; 8'he1: s=8'hf8; 8'he2: s=8'h98; 8'he3: s=8'h11;
                8'he4: s=8'h69; 8'he5: s=8'hd9; 8'he6: s=8'h8e; 8'he7: s=8'h94;
                8'he8: s=8'h9b; 8'he9: s=8'h1e; 8'hea: s=8'h87; 8'heb: s=8'he9;
                8'hec: s=8'hce; 8'hed: s=8'h55; 8'hee: s=8'h28; 8'hef: s=8'hdf;
                8'hf0: s=8'h8c; 8'hf1: s=8'ha1; 8'hf2: s=8'h89; 8'hf3: s=8'h0d;
                8'hf4: s=8'hbf; 8'hf5: s=8'he6; 8'hf6: s=8'h42; 8'hf7: s=8'h68;
                8'hf8: s=8'h41; 8'hf9: s=8'h99; 8'hfa: s=8'h2d; 8'hfb: s=8'h0f;
                8'hfc: s=8'hb0; 8'hfd: s=8'h54; 8'hfe: s=8'hbb; 8'hff: s=8'h16;
                default: s = 8'h00;
            endcase
            sbox = s;
        end
    endfunction

    // round constant for key schedule step r (1..10)
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] c;
        begin
            case (r)
                4'd1: c = 8'h01; 4'd2: c = 8'h02; 4'd3: c = 8'h04; 4'd4: c = 8'h08;
                4'd5: c = 8'h10; 4'd6: c = 8'h20; 4'd7: c = 8'h40; 4'd8: c = 8'h80;
                4'd9: c = 8'h1b; 4'd10: c = 8'h36;
                default: c = 8'h00;
            endcase
            rcon = c;
        end
    endfunction

    // one key schedule step: previous round key to next
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        begin
            t = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
            t = t ^ {rcon(r), 24'h0};
            w0 = k[127:96] ^ t;
            w1 = k[95:64] ^ w0;
            w2 = k[63:32] ^ w1;
            w3 = k[31:0] ^ w2;
            next_key = {w0, w1, w2, w3};
        end
    endfunction

    // SubBytes and ShiftRows; byte 0 in bits 127:120, column major
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        begin
            t = '0;
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    t[127 - 8 * (r + 4 * c) -: 8] =
                        sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
                end
            end
            sub_shift = t;
        end
    endfunction

    // MixColumns over all four columns
    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        begin
            t = '0;
            for (int c = 0; c < 4; c++)
            begin
                a0 = s[127 - 32 * c -: 8];
                a1 = s[119 - 32 * c -: 8];
                a2 = s[111 - 32 * c -: 8];
                a3 = s[103 - 32 * c -: 8];
                t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
            mix = t;
        end
    endfunction

endpackage

FILE: sv/aes128_block_encrypt.sv
// AES-128 encryptor: one round per pipeline stage, round keys precomputed.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall  | aes_pkg::plain_beat_t
//  out     | output    | out_valid/out_stall| aes_pkg::cipher_beat_t
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (64 bits)
//
// Initial AddRoundKey stage plus ten round stages; one beat per cycle sustained
// while in_stall is low. Round keys are expanded after a key write,
// one schedule step per cycle, and held in registers.
// Reset clears valid bits and key registers. A stall on out freezes the round
// pipeline while its last stage holds a beat, and in_stall then follows out_stall.
// in_stall is also high for one cycle after reset and after each key write.
module aes128_block_encrypt #(
    parameter int unsigned Rounds = aes_pkg::NumRounds
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  aes_pkg::plain_beat_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output aes_pkg::cipher_beat_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [63:0]           cfg_data
);

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic [127:0] rk_reg [Rounds+1];
    logic [127:0] st_reg [Rounds+1];
    logic         vld_reg [Rounds+1];
    logic         key_busy_reg;
    logic         advance;

    assign cfg_ready = 1'b1;

    // pipeline moves unless the last stage holds a beat that is stalled
    assign advance  = !(vld_reg[Rounds] && out_stall);
    assign in_stall = !advance || key_busy_reg;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                aes_pkg::CfgKeyHigh: key_high_reg <= cfg_data;
                aes_pkg::CfgKeyLow:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // hold input until the current key has reached the first round key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_busy_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_busy_reg <= 1'b1;
        end
        else
        begin
            key_busy_reg <= 1'b0;
        end
    end

    // round key chain: each register one schedule step from the previous
    always_ff @(posedge clk)
    begin
        rk_reg[0] <= {key_high_reg, key_low_reg};
        for (int r = 1; r <= Rounds; r++)
        begin
            rk_reg[r] <= aes_pkg::next_key(rk_reg[r-1], 4'(r));
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r <= Rounds; r++)
            begin
                vld_reg[r] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid && !key_busy_reg;
            for (int r = 1; r <= Rounds; r++)
            begin
                vld_reg[r] <= vld_reg[r-1];
            end
        end
    end

    // round datapath
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0] <= {in_data.plain_high, in_data.plain_low} ^ rk_reg[0];
            for (int r = 1; r < Rounds; r++)
            begin
                st_reg[r] <= aes_pkg::mix(aes_pkg::sub_shift(st_reg[r-1])) ^ rk_reg[r];
            end
            st_reg[Rounds] <= aes_pkg::sub_shift(st_reg[Rounds-1]) ^ rk_reg[Rounds];
        end
    end

    assign out_valid            = vld_reg[Rounds];
    assign out_data.cipher_high = st_reg[Rounds][127:64];
    assign out_data.cipher_low  = st_reg[Rounds][63:0];

endmodule

FILE: sv/aes_checker.sv
// Port-level checker for the AES-128 encryptor, bound to the top level.
`include "aes128_block_encrypt_macros.svh"
module aes_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input aes_pkg::cipher_beat_t out_data,
    input logic                  cfg_ready
);
    // stalled result beat holds
    `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "out beat changed under stall")
    // a stalled result beat stalls the input
    `AES_ASSERT_IMP(a_stall_src, clk, rst_n, out_valid && out_stall, in_stall, "in not stalled behind out")
    // config port always ready
    `AES_ASSERT_IMP(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "cfg not ready")
endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_ready(cfg_ready)
);

FILE: tb/sv/tb_aes128_block_encrypt.sv
// Self-checking testbench for the AES-128 block encryptor with its own cipher predictor.
module tb_aes128_block_encrypt;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    aes_pkg::plain_beat_t  in_data;
    logic                  out_valid;
    logic                  out_stall;
    aes_pkg::cipher_beat_t out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [63:0]           cfg_data;

    aes128_block_encrypt u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor key copy, S-box table and block queues
    logic [63:0]           cur_key_high;
    logic [63:0]           cur_key_low;
    logic [7:0]            sub_table [256];
    aes_pkg::plain_beat_t  plain_queue[$];
    aes_pkg::cipher_beat_t cipher_queue[$];
    int                    errors;
    logic                  in_fire;
    int                    in_gap;
    int                    out_gap;
    bit                    in_quiet;
    bit                    out_quiet;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // GF(2^8) product with the AES polynomial
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[0])
                acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return acc;
    endfunction

    // S-box from inverse x^254 and the affine map; zero inverts to zero
    function automatic logic [7:0] sub_byte_calc(input logic [7:0] x);
        logic [7:0] sq;
        logic [7:0] inv;
        logic [7:0] y;
        sq = gf_product(x, x);
        inv = sq;
        for (int k = 0; k < 6; k++)
        begin
            sq = gf_product(sq, sq);
            inv = gf_product(inv, sq);
        end
        y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return y;
    endfunction

    // full AES-128 encryption of one block under the current key
    function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                   input logic [127:0] plain);
        logic [31:0]  w [44];
        logic [31:0]  t;
        logic [7:0]   st [16];
        logic [7:0]   tmp [16];
        logic [7:0]   rc;
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
            w[i] = key[127 - 32 * i -: 32];
        for (int i = 4; i < 44; i++)
        begin
            t = w[i - 1];
            if (i % 4 == 0)
            begin
                t = {sub_table[t[23:16]], sub_table[t[15:8]], sub_table[t[7:0]],
                     sub_table[t[31:24]]} ^ {rc, 24'h0};
                rc = gf_product(rc, 8'h02);
            end
            w[i] = w[i - 4] ^ t;
        end
        for (int b = 0; b < 16; b++)
            st[b] = plain[127 - 8 * b -: 8] ^ w[b / 4][31 - 8 * (b % 4) -: 8];
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            // SubBytes with row r rotated left by r columns
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[r + 4 * c] = sub_table[st[r + 4 * ((c + r) % 4)]];
            st = tmp;
            if (rnd < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[4 * c];
                    a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2];
                    a3 = st[4 * c + 3];
                    st[4 * c]     = gf_product(8'h02, a0) ^ gf_product(8'h03, a1) ^ a2 ^ a3;
                    st[4 * c + 1] = a0 ^ gf_product(8'h02, a1) ^ gf_product(8'h03, a2) ^ a3;
                    st[4 * c + 2] = a0 ^ a1 ^ gf_product(8'h02, a2) ^ gf_product(8'h03, a3);
                    st[4 * c + 3] = gf_product(8'h03, a0) ^ a1 ^ a2 ^ gf_product(8'h02, a3);
                end
            end
            for (int b = 0; b < 16; b++)
                st[b] ^= w[4 * rnd + b / 4][31 - 8 * (b % 4) -: 8];
        end
        for (int b = 0; b < 16; b++)
            res[127 - 8 * b -: 8] = st[b];
        return res;
    endfunction

    // append one block to the pending input queue
    function automatic void enqueue_plain(input aes_pkg::plain_beat_t p);
        plain_queue.insert(plain_queue.size(), p);
    endfunction

    // gap length: none when quiet, otherwise mostly none, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // input driver: holds a stalled beat, otherwise inserts gaps or pops the next block
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
            in_quiet <= 1'b0;
        end
        else if (in_valid && !in_fire)
        begin
            in_valid <= 1'b1;
        end
        else if (in_gap > 0)
        begin
            in_valid <= 1'b0;
            in_gap   <= in_gap - 1;
        end
        else if (plain_queue.size() > 0)
        begin
            in_valid <= 1'b1;
            in_data  <= plain_queue.pop_front();
            in_gap   <= pick_gap(in_quiet);
            if ($urandom_range(0, 63) == 0)
                in_quiet <= !in_quiet;
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // output backpressure
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
            out_quiet <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap   <= out_gap - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            out_gap   <= pick_gap(out_quiet);
            if ($urandom_range(0, 63) == 0)
                out_quiet <= !out_quiet;
        end
    end

    // monitor: predict on accepted input beats, check accepted output beats
    always @(posedge clk)
    begin
        aes_pkg::cipher_beat_t want;
        in_fire = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                in_fire = 1'b1;
                cipher_queue.insert(cipher_queue.size(),
                                    encrypt_block({cur_key_high, cur_key_low}, in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (cipher_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected cipher beat %h", $realtime, out_data);
                end
                else
                begin
                    want = cipher_queue.pop_front();
                    if (out_data.cipher_high !== want.cipher_high)
                    begin
                        errors++;
                        $display("%0t: cipher_high expected %h got %h", $realtime,
                                 want.cipher_high, out_data.cipher_high);
                    end
                    if (out_data.cipher_low !== want.cipher_low)
                    begin
                        errors++;
                        $display("%0t: cipher_low expected %h got %h", $realtime,
                                 want.cipher_low, out_data.cipher_low);
                    end
                end
            end
        end
    end

    // wait until nothing is queued, in flight or expected, then let the pipe settle
    task automatic wait_idle();
        @(posedge clk);
        while (plain_queue.size() > 0 || in_valid || cipher_queue.size() > 0)
            @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    task automatic write_key_reg(input logic idx, input logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // load a new key while idle and give the schedule time to expand
    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        wait_idle();
        write_key_reg(aes_pkg::CfgKeyHigh, hi);
        write_key_reg(aes_pkg::CfgKeyLow, lo);
        cur_key_high = hi;
        cur_key_low  = lo;
        repeat (20) @(posedge clk);
    endtask

    function automatic aes_pkg::plain_beat_t rand_block();
        aes_pkg::plain_beat_t p;
        p = {$urandom(), $urandom(), $urandom(), $urandom()};
        // sparse blocks reach the zero byte of the S-box often
        if ($urandom_range(0, 3) == 0)
            for (int b = 0; b < 16; b++)
                if ($urandom_range(0, 1))
                    p[127 - 8 * b -: 8] = 8'h00;
        return p;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            enqueue_plain(rand_block());
            // halfway through, the sender holds off until the whole pipe has drained
            if (i == count / 2)
                wait_idle();
        end
    endtask

    // stimulus
    initial
    begin
        errors       = 0;
        in_fire      = 1'b0;
        cur_key_high = '0;
        cur_key_low  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = aes_pkg::CfgKeyHigh;
        cfg_data     = '0;
        for (int v = 0; v < 256; v++)
            sub_table[v] = sub_byte_calc(v[7:0]);
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // key left at its reset value of zero
        enqueue_plain('0);
        enqueue_plain('1);
        enqueue_plain(128'h00112233445566778899aabbccddeeff);
        random_phase(60);

        // standard example key
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        enqueue_plain(128'h00112233445566778899aabbccddeeff);
        enqueue_plain('0);
        enqueue_plain('1);
        enqueue_plain({16{8'haa}});
        enqueue_plain({16{8'h55}});
        enqueue_plain({64'hffffffffffffffff, 64'h0});
        enqueue_plain({64'h0, 64'hffffffffffffffff});
        for (int b = 0; b < 128; b += 17)
            enqueue_plain(128'h1 << b);
        random_phase(200);

        // extreme keys, then several random ones
        load_key('1, '1);
        enqueue_plain('0);
        enqueue_plain('1);
        random_phase(180);
        load_key('0, '1);
        random_phase(150);
        for (int k = 0; k < 4; k++)
        begin
            load_key({$urandom(), $urandom()}, {$urandom(), $urandom()});
            random_phase(150);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_aes128_block_encrypt passed");
        else
            $display("tb_aes128_block_encrypt failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("tb_aes128_block_encrypt failed");
        $finish;
    end

endmodule

FILE: aes128_block_encrypt.f
+incdir+sv
sv/aes_pkg.sv
sv/aes128_block_encrypt.sv
sv/aes_checker.sv
tb/sv/tb_aes128_block_encrypt.sv
